// File: sv/ded_pkg.sv
// Shared constants and types of the depth edge darkening block.
// Used by the top level, the output buffer and the bench.
package ded_pkg;

  // Row storage and geometry
  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = $clog2(MAX_WIDTH + 1);
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int CLIP_W     = 13;

  // Register field widths
  localparam int FW_W  = 11;
  localparam int FH_W  = 13;
  localparam int THR_W = 32;
  localparam int FAC_W = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_TOP       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_RIGHT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_BOTTOM    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_THRESHOLD = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DARKEN_FACTOR  = 3'd7;

  // Register reset values
  localparam logic [FW_W-1:0]   RST_FRAME_WIDTH    = 11'd1024;
  localparam logic [FH_W-1:0]   RST_FRAME_HEIGHT   = 13'd1024;
  localparam logic [CLIP_W-1:0] RST_CLIP_LEFT      = 13'd0;
  localparam logic [CLIP_W-1:0] RST_CLIP_TOP       = 13'd0;
  localparam logic [CLIP_W-1:0] RST_CLIP_RIGHT     = 13'd4096;
  localparam logic [CLIP_W-1:0] RST_CLIP_BOTTOM    = 13'd4096;
  localparam logic [THR_W-1:0]  RST_JUMP_THRESHOLD = 32'd65536;
  localparam logic [FAC_W-1:0]  RST_DARKEN_FACTOR  = 9'd128;

  // Input op codes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Color masks
  localparam logic [31:0] TOP_BYTE  = 32'hFF00_0000;
  localparam logic [7:0]  CHAN_MASK = 8'hFF;

  // Output buffer (depth a power of two)
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [31:0] color;
    logic        darkened;
    logic        eof;
  } out_item_t;

endpackage

// File: sv/ded_ifs.sv
// Valid/ready channel interfaces for the pixel input and the result output.
// Stand alone; no package needed.
interface ded_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [31:0]        pixel_color;
  logic signed [31:0] depth_value;
  logic               is_empty;

  modport source (output valid, op, pixel_color, depth_value, is_empty, input ready);
  modport sink (input valid, op, pixel_color, depth_value, is_empty, output ready);
endinterface

interface ded_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_color;
  logic        was_darkened;
  logic        end_of_frame;

  modport source (output valid, out_color, was_darkened, end_of_frame, input ready);
  modport sink (input valid, out_color, was_darkened, end_of_frame, output ready);
endinterface

// File: sv/ded_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read returns the old contents on a same-address write. No dependencies.
module ded_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/ded_out_buf.sv
// Small result FIFO that drives the output channel.
// Depends on ded_pkg and ded_out_if.
module ded_out_buf (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  ded_pkg::out_item_t             push_item,
  output logic [ded_pkg::FIFO_CNT_W-1:0] count,
  ded_out_if.source                      result
);

  ded_pkg::out_item_t                  mem [ded_pkg::FIFO_DEPTH];
  logic [ded_pkg::FIFO_PTR_W-1:0]      wr_ptr;
  logic [ded_pkg::FIFO_PTR_W-1:0]      rd_ptr;
  logic                                pop;
  ded_pkg::out_item_t                  head;

  assign pop  = result.valid && result.ready;
  assign head = mem[rd_ptr];

  assign result.valid        = count != '0;
  assign result.out_color    = head.color;
  assign result.was_darkened = head.darkened;
  assign result.end_of_frame = head.eof;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + ded_pkg::FIFO_CNT_W'(push) - ded_pkg::FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// File: sv/depth_edge_darken.sv
// Silhouette darkening of a raster pixel stream by depth discontinuity.
// A pixel's result passes s1, s2 and the output buffer after the item of the pixel below
// it (or a drain item) is accepted; one item per cycle is sustained when output flows,
// set by the row RAM read one entry ahead. The drain of the last row takes one item per
// pixel of the row. Reset (rst, synchronous) clears positions, counters and the output
// buffer; the row RAM is not cleared and holds whatever it held.
module depth_edge_darken (
  input  logic                              clk,
  input  logic                              rst,
  ded_in_if.sink                            pixel,
  ded_out_if.source                         result,
  input  logic                              cfg_we,
  input  logic [ded_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ded_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // One row RAM entry: depth of the row above, depth and color of the center row.
  // Depth words carry the empty flag in bit 32.
  typedef struct packed {
    logic [32:0] above;
    logic [32:0] center;
    logic [31:0] color;
  } entry_t;

  typedef struct packed {
    logic                         emit;
    logic                         wr;
    logic                         eof;
    logic                         in_clip;
    logic                         use_l;
    logic                         use_r;
    logic                         use_a;
    logic                         use_b;
    logic [ded_pkg::COL_W-1:0]    raddr;
    logic [ded_pkg::COL_W-1:0]    waddr;
    logic [32:0]                  below;
    logic [31:0]                  color;
  } s1_t;

  typedef struct packed {
    logic        mark;
    logic [31:0] color;
    logic        eof;
  } s2_t;

  // Configuration registers
  logic [ded_pkg::FW_W-1:0]   frame_width;
  logic [ded_pkg::FH_W-1:0]   frame_height;
  logic [ded_pkg::CLIP_W-1:0] clip_left;
  logic [ded_pkg::CLIP_W-1:0] clip_top;
  logic [ded_pkg::CLIP_W-1:0] clip_right;
  logic [ded_pkg::CLIP_W-1:0] clip_bottom;
  logic [ded_pkg::THR_W-1:0]  jump_threshold;
  logic [ded_pkg::FAC_W-1:0]  darken_factor;

  // Position state
  logic [ded_pkg::COL_W-1:0] col, col_next;
  logic [ded_pkg::ROW_W-1:0] row, row_next;
  logic [ded_pkg::WID_W-1:0] pending, pending_next;

  // Front end signals
  logic                       acc;
  logic                       go;
  logic                       pend;
  logic                       last;
  logic [ded_pkg::WID_W-1:0]  wid;
  logic [ded_pkg::CLIP_W-1:0] wid13;
  logic [ded_pkg::CLIP_W-1:0] hgt;
  logic [ded_pkg::CLIP_W-1:0] cx1;
  logic [ded_pkg::CLIP_W-1:0] cy1;
  logic [ded_pkg::CLIP_W-1:0] x13;
  logic [ded_pkg::CLIP_W-1:0] y13;
  logic [ded_pkg::ROW_W-1:0]  emit_row;
  s1_t                        s1_next;

  // Pipeline registers
  logic   s1_valid;
  s1_t    s1;
  logic   s2_valid;
  s2_t    s2;
  entry_t cur;
  logic [32:0] left;
  logic   fwd_hit;
  entry_t fwd_data;

  // Row RAM
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t                    dfix;
  entry_t                    wdata;
  entry_t                    cur_next;
  logic signed [33:0]        limit;
  logic                      mark;

  // Output side
  logic [ded_pkg::FIFO_CNT_W-1:0] buf_count;
  logic [ded_pkg::FIFO_CNT_W:0]   credit_used;
  ded_pkg::out_item_t             push_item;

  function automatic logic breaks(logic [32:0] nb, logic signed [33:0] lim);
    breaks = nb[32] || ($signed({nb[31], nb[31], nb[31:0]}) < lim);
  endfunction

  function automatic logic [7:0] scale_chan(logic [7:0] v, logic [8:0] f);
    logic [16:0] prod;
    logic [8:0]  s;
    prod = 17'(v) * 17'(f);
    s = prod[16:8];
    scale_chan = (s > 9'(ded_pkg::CHAN_MASK)) ? ded_pkg::CHAN_MASK : s[7:0];
  endfunction

  function automatic logic [31:0] shade(logic [31:0] c, logic [8:0] f);
    shade = (c & ded_pkg::TOP_BYTE) |
            {8'h00, scale_chan(c[23:16], f), scale_chan(c[15:8], f), scale_chan(c[7:0], f)};
  endfunction

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= ded_pkg::RST_FRAME_WIDTH;
      frame_height   <= ded_pkg::RST_FRAME_HEIGHT;
      clip_left      <= ded_pkg::RST_CLIP_LEFT;
      clip_top       <= ded_pkg::RST_CLIP_TOP;
      clip_right     <= ded_pkg::RST_CLIP_RIGHT;
      clip_bottom    <= ded_pkg::RST_CLIP_BOTTOM;
      jump_threshold <= ded_pkg::RST_JUMP_THRESHOLD;
      darken_factor  <= ded_pkg::RST_DARKEN_FACTOR;
    end else if (cfg_we) begin
      case (cfg_index)
        ded_pkg::CFG_FRAME_WIDTH:    frame_width    <= cfg_data[ded_pkg::FW_W-1:0];
        ded_pkg::CFG_FRAME_HEIGHT:   frame_height   <= cfg_data[ded_pkg::FH_W-1:0];
        ded_pkg::CFG_CLIP_LEFT:      clip_left      <= cfg_data[ded_pkg::CLIP_W-1:0];
        ded_pkg::CFG_CLIP_TOP:       clip_top       <= cfg_data[ded_pkg::CLIP_W-1:0];
        ded_pkg::CFG_CLIP_RIGHT:     clip_right     <= cfg_data[ded_pkg::CLIP_W-1:0];
        ded_pkg::CFG_CLIP_BOTTOM:    clip_bottom    <= cfg_data[ded_pkg::CLIP_W-1:0];
        ded_pkg::CFG_JUMP_THRESHOLD: jump_threshold <= cfg_data[ded_pkg::THR_W-1:0];
        ded_pkg::CFG_DARKEN_FACTOR:  darken_factor  <= cfg_data[ded_pkg::FAC_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- front end
  assign credit_used = (ded_pkg::FIFO_CNT_W + 1)'(buf_count) +
                       (ded_pkg::FIFO_CNT_W + 1)'(s1_valid) +
                       (ded_pkg::FIFO_CNT_W + 1)'(s2_valid);
  assign pixel.ready = !rst && (credit_used < (ded_pkg::FIFO_CNT_W + 1)'(ded_pkg::FIFO_DEPTH));
  assign acc = pixel.valid && pixel.ready;

  always_comb begin
    // Zero acts as one, large sizes are capped
    if (frame_width == '0) begin
      wid = ded_pkg::WID_W'(1);
    end else if (ded_pkg::CLIP_W'(frame_width) > ded_pkg::CLIP_W'(ded_pkg::MAX_WIDTH)) begin
      wid = ded_pkg::WID_W'(ded_pkg::MAX_WIDTH);
    end else begin
      wid = ded_pkg::WID_W'(frame_width);
    end
    if (frame_height == '0) begin
      hgt = ded_pkg::CLIP_W'(1);
    end else if (frame_height > ded_pkg::CLIP_W'(ded_pkg::MAX_HEIGHT)) begin
      hgt = ded_pkg::CLIP_W'(ded_pkg::MAX_HEIGHT);
    end else begin
      hgt = frame_height;
    end
    wid13 = ded_pkg::CLIP_W'(wid);
    cx1   = (clip_right < wid13) ? clip_right : wid13;
    cy1   = (clip_bottom < hgt) ? clip_bottom : hgt;

    pend     = pending != '0;
    last     = pending == ded_pkg::WID_W'(1);
    emit_row = pend ? row : row - 1'b1;
    x13      = ded_pkg::CLIP_W'(col);
    y13      = ded_pkg::CLIP_W'(emit_row);

    col_next     = col;
    row_next     = row;
    pending_next = pending;
    go           = 1'b0;

    s1_next.emit    = 1'b0;
    s1_next.wr      = 1'b0;
    s1_next.eof     = 1'b0;
    s1_next.in_clip = x13 >= clip_left && x13 < cx1 && y13 >= clip_top && y13 < cy1;
    s1_next.use_l   = col != '0 && (x13 - 1'b1) >= clip_left;
    s1_next.use_r   = (x13 + 1'b1) < cx1;
    s1_next.use_a   = emit_row != '0 && (y13 - 1'b1) >= clip_top;
    s1_next.use_b   = (y13 + 1'b1) < cy1;
    s1_next.waddr   = col;
    s1_next.below   = {pixel.is_empty, pixel.depth_value};
    s1_next.color   = pixel.pixel_color;

    if (acc) begin
      if (pend) begin
        // Flush the last row, whatever the op
        go           = 1'b1;
        s1_next.emit = 1'b1;
        s1_next.eof  = last;
        pending_next = pending - 1'b1;
        if (last || col == ded_pkg::COL_W'(ded_pkg::MAX_WIDTH - 1)) begin
          col_next     = '0;
          row_next     = '0;
          pending_next = '0;
        end else begin
          col_next = col + 1'b1;
        end
      end else if (pixel.op == ded_pkg::OP_PIXEL) begin
        go           = 1'b1;
        s1_next.emit = row != '0;
        s1_next.wr   = 1'b1;
        if ((x13 + 1'b1) >= wid13) begin
          col_next = '0;
          if ((ded_pkg::CLIP_W'(row) + 1'b1) >= hgt) begin
            pending_next = wid;
          end else begin
            row_next = row + 1'b1;
          end
        end else begin
          col_next = col + 1'b1;
        end
      end
    end
    // Prefetch the entry of the column the next item lands on
    s1_next.raddr = col_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      pending  <= '0;
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      col      <= col_next;
      row      <= row_next;
      pending  <= pending_next;
      s1_valid <= go;
      if (go) begin
        // A write landing on the address read at the same edge is missed by the RAM
        fwd_hit <= s1_valid && s1.wr && (s1.waddr == col_next);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      s1       <= s1_next;
      fwd_data <= wdata;
    end
  end

  // ---------------------------------------------------------------- row RAM
  ded_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ded_pkg::MAX_WIDTH)
  ) u_row_ram (
    .clk   (clk),
    .we    (s1_valid && s1.wr),
    .waddr (s1.waddr),
    .wdata (wdata),
    .re    (go),
    .raddr (col_next),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- neighbor compare
  always_comb begin
    dfix  = fwd_hit ? fwd_data : entry_t'(ram_rdata);
    limit = $signed({cur.center[31], cur.center[31], cur.center[31:0]}) -
            $signed({jump_threshold[31], jump_threshold[31], jump_threshold});
    mark  = s1.emit && s1.in_clip && !cur.center[32] &&
            ((s1.use_l && breaks(left, limit)) ||
             (s1.use_r && breaks(dfix.center, limit)) ||
             (s1.use_a && breaks(cur.above, limit)) ||
             (s1.use_b && breaks(s1.below, limit)));

    // Center row moves up, the new pixel becomes center
    wdata.above  = cur.center;
    wdata.center = s1.below;
    wdata.color  = s1.color;

    // Own write lands on the next column only on a one-pixel row
    cur_next = (s1.wr && s1.waddr == s1.raddr) ? wdata : dfix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      left     <= '0;
    end else begin
      s2_valid <= s1_valid && s1.emit;
      if (s1_valid && s1.emit) begin
        left <= cur.center;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      cur <= cur_next;
    end
    if (s1_valid && s1.emit) begin
      s2.mark  <= mark;
      s2.color <= cur.color;
      s2.eof   <= s1.eof;
    end
  end

  // ---------------------------------------------------------------- shade and output
  always_comb begin
    push_item.color    = s2.mark ? shade(s2.color, darken_factor) : s2.color;
    push_item.darkened = s2.mark;
    push_item.eof      = s2.eof;
  end

  ded_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_valid),
    .push_item (push_item),
    .count     (buf_count),
    .result    (result)
  );

endmodule

// File: sv/ded_checker.sv
// Port-level assertions for depth_edge_darken, attached by the bind below.
// Depends on the top level's ports only.
module ded_checker (
  input logic        clk,
  input logic        rst,
  input logic        pixel_valid,
  input logic        pixel_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] out_color,
  input logic        was_darkened,
  input logic        end_of_frame
);

  // Reset empties the output buffer
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // Input stalls only while results are backed up
  a_stall_backlog: assert property (@(posedge clk) disable iff (rst)
    !pixel_ready |-> result_valid)
    else $error("input stalled with no result waiting");

  // A result appearing in an empty buffer comes from an accepted item carried through s1, s2 and the buffer write
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(pixel_valid && pixel_ready, 3))
    else $error("result without an item accepted three cycles before");

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(out_color) && $stable(was_darkened) && $stable(end_of_frame))
    else $error("stalled result changed");

endmodule

bind depth_edge_darken ded_checker u_ded_checker (
  .clk          (clk),
  .rst          (rst),
  .pixel_valid  (pixel.valid),
  .pixel_ready  (pixel.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .out_color    (result.out_color),
  .was_darkened (result.was_darkened),
  .end_of_frame (result.end_of_frame)
);

// File: test/tb.sv
// Self-checking bench for depth_edge_darken: streams whole frames through the valid/ready
// pixel channel, predicts every emitted pixel in step with each accepted item.
// Depends on ded_pkg and the channel interfaces in ded_ifs.sv.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ded_pkg::*;

  typedef struct packed {
    logic        op;
    logic [31:0] color;
    logic [31:0] depth;
    logic        is_empty;
  } px_item_t;

  localparam logic [32:0] EMPTY_FLAG = 33'h1_0000_0000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ded_in_if  pix_if ();
  ded_out_if res_if ();

  depth_edge_darken dut (
    .clk(clk), .rst(rst), .pixel(pix_if), .result(res_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5ns clk = ~clk;

  // Pixel stream waiting to be offered, and output pixels predicted but not yet seen
  px_item_t  px_feed_q[$];
  out_item_t shaded_q[$];

  // Shadow of the block: register copies, row stores and raster position
  logic [FW_W-1:0]   sh_width;
  logic [FH_W-1:0]   sh_height;
  logic [CLIP_W-1:0] sh_left, sh_top, sh_right, sh_bottom;
  logic [THR_W-1:0]  sh_thresh;
  logic [FAC_W-1:0]  sh_factor;
  logic [32:0]       above_row [MAX_WIDTH];
  logic [32:0]       mid_row [MAX_WIDTH];
  logic [31:0]       mid_color [MAX_WIDTH];
  logic [32:0]       left_px;
  int unsigned       col_pos, row_pos, flush_left;

  int unsigned fail_cnt, results_seen, items_taken, settings_cnt;
  int unsigned hold_asked, hold_seen, hold_left;
  int unsigned burst_left, gap_left;
  logic [31:0] rx_tick;
  int unsigned rx_mode;
  bit          px_accepted;

  function automatic int unsigned live_width();
    int unsigned w;
    w = (sh_width == 0) ? 1 : sh_width;
    return (w > MAX_WIDTH) ? MAX_WIDTH : w;
  endfunction

  function automatic int unsigned live_height();
    int unsigned h;
    h = (sh_height == 0) ? 1 : sh_height;
    return (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
  endfunction

  function automatic logic [7:0] scale_chan(logic [7:0] v);
    logic [16:0] s;
    s = v * sh_factor;
    s = s >> 8;
    return (s > CHAN_MASK) ? CHAN_MASK : s[7:0];
  endfunction

  function automatic logic [31:0] shade_px(logic [31:0] c);
    return (c & TOP_BYTE) |
           {8'h00, scale_chan(c[23:16]), scale_chan(c[15:8]), scale_chan(c[7:0])};
  endfunction

  function automatic bit is_edge(logic [32:0] nb, longint lim);
    return nb[32] || (longint'($signed(nb[31:0])) < lim);
  endfunction

  // Output pixel (x, y) of the center row; below is the depth entry of row y + 1
  function automatic out_item_t shade_center(int unsigned x, int unsigned y,
                                             logic [32:0] below, bit eof);
    int unsigned w, h, cx1, cy1;
    logic [32:0] mid;
    longint      lim;
    bit          mark;
    out_item_t   r;
    w = live_width();
    h = live_height();
    cx1 = (sh_right < w) ? sh_right : w;
    cy1 = (sh_bottom < h) ? sh_bottom : h;
    mid = mid_row[x];
    mark = 1'b0;
    if (x >= sh_left && x < cx1 && y >= sh_top && y < cy1 && !mid[32]) begin
      // 33-bit wide difference, never wraps
      lim = longint'($signed(mid[31:0])) - longint'($signed(sh_thresh));
      if (x > 0 && x - 1 >= sh_left && is_edge(left_px, lim)) mark = 1'b1;
      if (x + 1 < cx1 && x + 1 < MAX_WIDTH && is_edge(mid_row[x + 1], lim)) mark = 1'b1;
      if (y > 0 && y - 1 >= sh_top && is_edge(above_row[x], lim)) mark = 1'b1;
      if (y + 1 < cy1 && is_edge(below, lim)) mark = 1'b1;
    end
    r.color    = mark ? shade_px(mid_color[x]) : mid_color[x];
    r.darkened = mark;
    r.eof      = eof;
    left_px = mid;
    return r;
  endfunction

  function automatic void advance_raster(px_item_t it);
    int unsigned x, w;
    logic [32:0] entry;
    bit          last;
    x = (col_pos < MAX_WIDTH) ? col_pos : MAX_WIDTH - 1;
    w = live_width();
    if (flush_left > 0) begin
      // last row pending: any item flushes one pixel
      last = (flush_left == 1);
      shaded_q.push_back(shade_center(x, row_pos, EMPTY_FLAG, last));
      flush_left--;
      col_pos = x + 1;
      if (last || col_pos >= MAX_WIDTH) begin
        flush_left = 0;
        col_pos = 0;
        row_pos = 0;
      end
      return;
    end
    if (it.op == OP_DRAIN) return;
    entry = {it.is_empty, it.depth};
    if (row_pos > 0) shaded_q.push_back(shade_center(x, row_pos - 1, entry, 1'b0));
    above_row[x] = mid_row[x];
    mid_row[x]   = entry;
    mid_color[x] = it.color;
    if (x + 1 >= w) begin
      col_pos = 0;
      if (row_pos + 1 >= live_height()) flush_left = w;
      else row_pos++;
    end else begin
      col_pos = x + 1;
    end
  endfunction

  // Sender: bursts of random length separated by random gaps
  always @(negedge clk) begin
    if (rst) begin
      pix_if.valid <= 1'b0;
    end else if (!pix_if.valid || px_accepted) begin
      if (gap_left > 0) begin
        gap_left--;
        pix_if.valid <= 1'b0;
      end else if (px_feed_q.size() != 0) begin
        pix_if.valid       <= 1'b1;
        pix_if.op          <= px_feed_q[0].op;
        pix_if.pixel_color <= px_feed_q[0].color;
        pix_if.depth_value <= px_feed_q[0].depth;
        pix_if.is_empty    <= px_feed_q[0].is_empty;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern is picked anew whenever the low bits of rx_tick wrap to zero, plus a long hold on request
  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      rx_tick = rx_tick + 1;
      if (rx_tick[4:0] == 5'd0) rx_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = 300;
        res_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= 1'($urandom_range(0, 1));
          2: res_if.ready <= ($urandom_range(0, 3) == 0);
          default: res_if.ready <= (rx_tick[2:0] != 3'd0);
        endcase
      end
    end
  end

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    out_item_t want, got;
    if (rst) begin
      px_accepted <= 1'b0;
    end else begin
      px_accepted <= pix_if.valid && pix_if.ready;
      if (pix_if.valid && pix_if.ready) begin
        advance_raster({pix_if.op, pix_if.pixel_color, pix_if.depth_value, pix_if.is_empty});
        void'(px_feed_q.pop_front());
        items_taken++;
      end
      if (res_if.valid && res_if.ready) begin
        got.color    = res_if.out_color;
        got.darkened = res_if.was_darkened;
        got.eof      = res_if.end_of_frame;
        results_seen++;
        if (shaded_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: unexpected pixel color %h dark %b eof %b",
                     $realtime, got.color, got.darkened, got.eof);
        end else begin
          want = shaded_q.pop_front();
          if (got.color !== want.color || got.darkened !== want.darkened ||
              got.eof !== want.eof) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("%0t: pixel %0d color %h/%h dark %b/%b eof %b/%b (expected/actual)",
                       $realtime, results_seen, want.color, got.color,
                       want.darkened, got.darkened, want.eof, got.eof);
          end
        end
      end
    end
  end

  task automatic push_px(logic op, logic [31:0] color, logic [31:0] depth, logic blank);
    px_feed_q.push_back('{op: op, color: color, depth: depth, is_empty: blank});
  endtask

  // Hold until everything offered is taken and every predicted pixel has come out
  task automatic wait_quiet(int unsigned tail);
    while (px_feed_q.size() != 0 || shaded_q.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_FRAME_WIDTH:    sh_width  = val[FW_W-1:0];
      CFG_FRAME_HEIGHT:   sh_height = val[FH_W-1:0];
      CFG_CLIP_LEFT:      sh_left   = val[CLIP_W-1:0];
      CFG_CLIP_TOP:       sh_top    = val[CLIP_W-1:0];
      CFG_CLIP_RIGHT:     sh_right  = val[CLIP_W-1:0];
      CFG_CLIP_BOTTOM:    sh_bottom = val[CLIP_W-1:0];
      CFG_JUMP_THRESHOLD: sh_thresh = val[THR_W-1:0];
      CFG_DARKEN_FACTOR:  sh_factor = val[FAC_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_geometry(logic [31:0] w, logic [31:0] h, logic [31:0] cl, logic [31:0] ct,
                              logic [31:0] cr, logic [31:0] cb, logic [31:0] thr,
                              logic [31:0] fac);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_CLIP_LEFT, cl);
    write_reg(CFG_CLIP_TOP, ct);
    write_reg(CFG_CLIP_RIGHT, cr);
    write_reg(CFG_CLIP_BOTTOM, cb);
    write_reg(CFG_JUMP_THRESHOLD, thr);
    write_reg(CFG_DARKEN_FACTOR, fac);
    settings_cnt++;
  endtask

  function automatic logic [31:0] pick_depth(logic [31:0] base);
    case ($urandom_range(0, 11))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom;
      default: return base + $urandom_range(0, 6) * 32'h8000;
    endcase
  endfunction

  // One whole frame, stray drains mixed in, then the flush of its last row
  task automatic queue_frame(bit pause_mid);
    int unsigned w, h;
    logic [31:0] base;
    w = live_width();
    h = live_height();
    base = $urandom;
    for (int unsigned i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 15) == 0)
        push_px(OP_DRAIN, $urandom, $urandom, 1'($urandom_range(0, 1)));
      push_px(OP_PIXEL, $urandom, pick_depth(base), $urandom_range(0, 7) == 0);
      if (pause_mid && i == (w * h) / 2) wait_quiet(0);
    end
    for (int unsigned i = 0; i < w; i++)
      push_px(1'($urandom_range(0, 1)), $urandom, $urandom, 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 2) == 0) push_px(OP_DRAIN, $urandom, $urandom, 1'b1);
  endtask

  task automatic random_geometry();
    logic [31:0] w, h, cl, ct, cr, cb, thr, fac;
    w  = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
    h  = $urandom_range(1, 6);
    cl = ($urandom_range(0, 2) == 0) ? $urandom_range(0, w) : 0;
    ct = ($urandom_range(0, 2) == 0) ? $urandom_range(0, h) : 0;
    cr = ($urandom_range(0, 1) == 0) ? 4096 : $urandom_range(0, w + 1);
    cb = ($urandom_range(0, 1) == 0) ? 4096 : $urandom_range(0, h + 1);
    case ($urandom_range(0, 6))
      0: thr = 32'd65536;
      1: thr = 32'd0;
      2: thr = 32'h8000_0000;
      3: thr = 32'h7FFF_FFFF;
      4: thr = 32'hFFFF_0000;
      5: thr = $urandom;
      default: thr = $urandom_range(0, 4) * 32'h8000;
    endcase
    case ($urandom_range(0, 5))
      0: fac = 0;
      1: fac = 256;
      2: fac = 511;
      3: fac = $urandom_range(257, 511);
      default: fac = $urandom_range(0, 256);
    endcase
    set_geometry(w, h, cl, ct, cr, cb, thr, fac);
  endtask

  initial begin
    int unsigned rand_items;
    pix_if.valid = 1'b0;
    pix_if.op = OP_PIXEL;
    pix_if.pixel_color = '0;
    pix_if.depth_value = '0;
    pix_if.is_empty = 1'b0;
    res_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_FRAME_WIDTH;
    cfg_data = '0;
    sh_width = RST_FRAME_WIDTH;   sh_height = RST_FRAME_HEIGHT;
    sh_left = RST_CLIP_LEFT;      sh_top = RST_CLIP_TOP;
    sh_right = RST_CLIP_RIGHT;    sh_bottom = RST_CLIP_BOTTOM;
    sh_thresh = RST_JUMP_THRESHOLD;
    sh_factor = RST_DARKEN_FACTOR;
    foreach (mid_row[i]) begin
      above_row[i] = '0;
      mid_row[i] = '0;
      mid_color[i] = '0;
    end
    left_px = '0;
    col_pos = 0; row_pos = 0; flush_left = 0;
    rx_tick = '0; rx_mode = 0;
    rand_items = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // 3x3 frame, zero threshold, factor above one so channels saturate
    set_geometry(3, 3, 0, 0, 4096, 4096, 32'd0, 511);
    push_px(OP_DRAIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    push_px(OP_PIXEL, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
    push_px(OP_PIXEL, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
    push_px(OP_PIXEL, 32'h1234_5678, 32'h0000_0000, 1'b1);
    push_px(OP_PIXEL, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    push_px(OP_PIXEL, 32'h00FF_80FF, 32'h7FFF_FFFF, 1'b0);
    push_px(OP_PIXEL, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
    push_px(OP_PIXEL, 32'h8080_8080, 32'h7FFF_FFFF, 1'b0);
    push_px(OP_PIXEL, 32'h7F7F_7F7F, 32'h7FFF_FFFF, 1'b1);
    push_px(OP_PIXEL, 32'hFFFF_FFFF, 32'h0001_0000, 1'b0);
    // a pixel item during the flush only advances it
    push_px(OP_PIXEL, 32'hDEAD_BEEF, 32'h1234_5678, 1'b0);
    push_px(OP_DRAIN, 32'h0, 32'h0, 1'b0);
    push_px(OP_DRAIN, 32'h0, 32'h0, 1'b0);
    push_px(OP_DRAIN, 32'h0, 32'h0, 1'b0);
    wait_quiet(8);
    // largest positive threshold, unit factor, clipped on the left
    set_geometry(2, 2, 1, 0, 4096, 4096, 32'h7FFF_FFFF, 256);
    push_px(OP_PIXEL, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    push_px(OP_PIXEL, 32'hAABB_CCDD, 32'h8000_0000, 1'b0);
    push_px(OP_PIXEL, 32'h0000_0000, 32'h0000_0000, 1'b1);
    push_px(OP_PIXEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    push_px(OP_DRAIN, 32'h0, 32'h0, 1'b0);
    push_px(OP_PIXEL, 32'h5555_AAAA, 32'hAAAA_5555, 1'b1);
    wait_quiet(8);
    // single row, most negative threshold, factor zero
    set_geometry(2, 1, 0, 0, 4096, 4096, 32'h8000_0000, 0);
    push_px(OP_PIXEL, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
    push_px(OP_PIXEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    push_px(OP_DRAIN, 32'h0, 32'h0, 1'b0);
    push_px(OP_DRAIN, 32'h0, 32'h0, 1'b0);
    wait_quiet(8);

    // back up the output with a long hold, then pause the stream mid-frame
    set_geometry(16, 8, 0, 0, 4096, 4096, 32'd65536, 128);
    hold_asked++;
    queue_frame(1'b1);
    wait_quiet(8);

    while (rand_items < 440) begin
      random_geometry();
      repeat ($urandom_range(1, 3)) begin
        rand_items += live_width() * (live_height() + 1);
        queue_frame(1'b0);
      end
      wait_quiet(8);
    end

    // zero sizes standing for one
    set_geometry(0, 0, 4096, 4096, 0, 0, 32'd65536, 128);
    queue_frame(1'b0);
    wait_quiet(16);

    $display("Covered %0d items accepted and %0d pixels checked over %0d register settings,",
             items_taken, results_seen, settings_cnt);
    $display("including saturating factors, threshold extremes, clipping and zero sizes.");
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #6ms;
    $display("timeout with %0d pixels outstanding", shaded_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
